### src/vhfg_pkg.sv
// Shared types, register indexes and widths of the volume hole filler.
package vhfg_pkg;

  localparam int DEF_MAX_X = 64;
  localparam int DEF_MAX_Y = 64;
  localparam int Z_LIMIT   = 1024;
  localparam int POS_W     = 25;   // voxel counters; 127*127*1024 fits
  localparam int PLANE_W   = 14;
  localparam int NUM_W     = 45;   // 27 * 255 * 2^32 fits
  localparam int DEN_W     = 37;
  localparam int STORE_W   = 24;   // hit weight over intensity
  localparam logic [7:0] OPAQUE = 8'd255;

  typedef enum logic [2:0] {
    REG_SIZE_X = 3'd0,
    REG_SIZE_Y = 3'd1,
    REG_SIZE_Z = 3'd2,
    REG_FACE   = 3'd3,
    REG_EDGE   = 3'd4,
    REG_CORNER = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  intensity;
    logic [15:0] hit_weight;
  } in_word_t;

  typedef struct packed {
    logic [7:0] filled_value;
    logic [7:0] alpha;
    logic       final_voxel;
  } out_word_t;

  typedef struct packed {
    logic take;        // input word accepted
    logic restart;     // counters back to zero
    logic rd_center;   // read the store at the output voxel
    logic load_pass;   // copy the stored voxel to the result
    logic clr_acc;     // clear sums and neighbour walk
    logic nb_issue;    // read one neighbour, advance the walk
    logic div_init;    // load the divider
    logic div_step;    // one quotient bit
    logic put;         // write the output register, advance output
  } cmd_t;

  typedef struct packed {
    logic over;        // output counter past the volume
    logic emit;        // window of the next output voxel complete
    logic center_hit;  // stored voxel has nonzero weight
    logic nb_last;     // last neighbour of the walk
    logic div_last;    // last quotient bit
    logic out_free;    // output register can take a word
  } sts_t;

endpackage

### src/volume_hole_fill_gaussian_unit.sv
// Top level of the streamed 3x3x3 normalized-convolution hole filler.
//
//   channel   dir   handshake            word
//   in        in    in_valid/in_stall    in_word   (mode, intensity, hit_weight)
//   out       out   out_valid/out_stall  out_word  (filled_value, alpha, final_voxel)
//   cfg       in    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A word that emits nothing returns to idle after evaluation; an emitted voxel stored
// with weight is copied to the output, and a hole takes 27 store reads for the
// neighbours, a pipeline flush and an 8-bit divide, one store read port setting the pace.
// Reset is synchronous; input stays stalled after reset or a register write while
// plane and volume sizes settle. A waiting result does not block the next input
// word; a full output register holds the sequencer before its next put.
module volume_hole_fill_gaussian_unit #(
  parameter int MAX_X = vhfg_pkg::DEF_MAX_X,
  parameter int MAX_Y = vhfg_pkg::DEF_MAX_Y
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  vhfg_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output vhfg_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import vhfg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  vhfg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  vhfg_datapath #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

### src/vhfg_ram.sv
// Generic single write port RAM with registered read.
module vhfg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8323
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and read the array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/vhfg_ctrl.sv
// Sequencer of the hole filler: accept, evaluate, check, gather, flush, divide, put.
module vhfg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          cfg_valid,
  input  vhfg_pkg::sts_t sts,
  output vhfg_pkg::cmd_t cmd
);
  import vhfg_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EVAL   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_GATHER = 7'b0001000,
    S_FLUSH  = 7'b0010000,
    S_DIVIDE = 7'b0100000,
    S_PUT    = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] settle;
  logic [1:0] flush;

  assign in_stall = (state != S_IDLE) || (settle != 2'd0);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.take = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.over) begin
          cmd.restart = 1'b1;
          state_next = S_IDLE;
        end else if (sts.emit) begin
          cmd.rd_center = 1'b1;
          state_next = S_CHECK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (sts.center_hit) begin
          cmd.load_pass = 1'b1;
          state_next = S_PUT;
        end else begin
          cmd.clr_acc = 1'b1;
          state_next = S_GATHER;
        end
      end
      S_GATHER: begin
        cmd.nb_issue = 1'b1;
        if (sts.nb_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (flush == 2'd2) begin
          cmd.div_init = 1'b1;
          state_next = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.put = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // hold state, settle and flush counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      settle <= 2'd3;
      flush  <= 2'd0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        settle <= 2'd3;
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
      if (state == S_FLUSH) begin
        flush <= flush + 2'd1;
      end else begin
        flush <= 2'd0;
      end
    end
  end

  // one word at a time through the sequencer
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> (state == S_EVAL))
    else $error("take did not lead to evaluation");
  a_put_free: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> sts.out_free)
    else $error("put into a full output register");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input open while busy");

endmodule

### src/vhfg_datapath.sv
// Store, counters, neighbour gather, sums, divider and output register.
module vhfg_datapath #(
  parameter int MAX_X = vhfg_pkg::DEF_MAX_X,
  parameter int MAX_Y = vhfg_pkg::DEF_MAX_Y
) (
  input  logic                clk,
  input  logic                rst,
  input  vhfg_pkg::cmd_t      cmd,
  output vhfg_pkg::sts_t      sts,
  input  vhfg_pkg::in_word_t  in_word,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vhfg_pkg::out_word_t out_word
);
  import vhfg_pkg::*;

  localparam int DEPTH = 2 * MAX_X * MAX_Y + 2 * MAX_X + 3;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = AW + 2;

  // configuration registers
  logic [6:0]  size_x, size_y;
  logic [10:0] size_z;
  logic [15:0] face_w, edge_w, corner_w;
  logic [6:0]  sx, sy;
  logic [10:0] sz;
  logic [PLANE_W-1:0] plane;
  logic [POS_W-1:0]   total;

  // counters
  logic [POS_W-1:0] in_pos, out_pos;
  logic [AW-1:0]    wr_addr, out_addr;
  logic [6:0]       ox, oy;
  logic [10:0]      oz;

  // neighbour walk and pipeline
  logic [1:0]  ndx, ndy, ndz;
  logic        s1_v;
  logic [15:0] s1_k;
  logic        s2_v;
  logic [7:0]  s2_i;
  logic [31:0] s2_w;
  logic [NUM_W-1:0] num, rem;
  logic [DEN_W-1:0] den;
  logic [2:0]  dbit;
  logic [7:0]  quo;
  logic [7:0]  res_val, res_alpha;

  logic [STORE_W-1:0] rdata;
  logic [AW-1:0]      raddr, nb_addr;
  logic signed [SW-1:0] offs, tsum;
  logic               inb, is_center;
  logic [1:0]         nz;
  logic [15:0]        kw;
  logic [POS_W:0]     reach;
  logic [POS_W-1:0]   last_pos;
  logic               size_wr;
  logic [NUM_W-1:0]   dshift;
  logic               dge;
  logic [7:0]         quo_next;

  // clamp sizes
  always_comb begin
    sx = (size_x == 7'd0) ? 7'd1 : ((32'(size_x) > MAX_X) ? 7'(MAX_X) : size_x);
    sy = (size_y == 7'd0) ? 7'd1 : ((32'(size_y) > MAX_Y) ? 7'(MAX_Y) : size_y);
    sz = (size_z == 11'd0) ? 11'd1 :
         ((32'(size_z) > Z_LIMIT) ? 11'(Z_LIMIT) : size_z);
  end

  assign size_wr  = cfg_valid && (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
                                  cfg_index == REG_SIZE_Z);
  assign last_pos = total - POS_W'(1);

  // emission check
  always_comb begin
    reach = {1'b0, out_pos} + (POS_W + 1)'({7'b0, plane} + {14'b0, sx} + 21'd1);
    if (reach > {1'b0, last_pos}) begin
      reach = {1'b0, last_pos};
    end
    sts.over       = out_pos >= total;
    sts.emit       = reach < {1'b0, in_pos};
    sts.center_hit = rdata[STORE_W-1:8] != 16'd0;
    sts.nb_last    = (ndx == 2'd2) && (ndy == 2'd2) && (ndz == 2'd2);
    sts.div_last   = dbit == 3'd0;
    sts.out_free   = !out_valid || !out_stall;
  end

  // neighbour address, bounds and kernel weight
  always_comb begin
    offs = '0;
    if (ndx == 2'd0) offs = offs - SW'(1);
    if (ndx == 2'd2) offs = offs + SW'(1);
    if (ndy == 2'd0) offs = offs - SW'(sx);
    if (ndy == 2'd2) offs = offs + SW'(sx);
    if (ndz == 2'd0) offs = offs - SW'(plane);
    if (ndz == 2'd2) offs = offs + SW'(plane);
    tsum = $signed({2'b00, out_addr}) + offs;
    if (tsum < 0) begin
      tsum = tsum + SW'(DEPTH);
    end else if (tsum >= SW'(DEPTH)) begin
      tsum = tsum - SW'(DEPTH);
    end
    nb_addr = tsum[AW-1:0];
    inb = !(ndx == 2'd0 && ox == 7'd0) && !(ndx == 2'd2 && ox == sx - 7'd1) &&
          !(ndy == 2'd0 && oy == 7'd0) && !(ndy == 2'd2 && oy == sy - 7'd1) &&
          !(ndz == 2'd0 && oz == 11'd0) && !(ndz == 2'd2 && oz == sz - 11'd1);
    is_center = (ndx == 2'd1) && (ndy == 2'd1) && (ndz == 2'd1);
    nz = 2'(ndx != 2'd1) + 2'(ndy != 2'd1) + 2'(ndz != 2'd1);
    case (nz)
      2'd1:    kw = face_w;
      2'd2:    kw = edge_w;
      2'd3:    kw = corner_w;
      default: kw = 16'd0;
    endcase
    raddr = cmd.nb_issue ? nb_addr : out_addr;
  end

  // divider step
  always_comb begin
    dshift   = NUM_W'(den) << dbit;
    dge      = rem >= dshift;
    quo_next = quo;
    quo_next[dbit] = dge;
  end

  vhfg_ram #(.WIDTH(STORE_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.take && !in_word.mode && (in_pos < total)),
    .waddr (wr_addr),
    .wdata ({in_word.hit_weight, in_word.intensity}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // configuration and derived sizes
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x   <= 7'd64;
      size_y   <= 7'd64;
      size_z   <= 11'd64;
      face_w   <= 16'd8103;
      edge_w   <= 16'd90;
      corner_w <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SIZE_X: size_x   <= cfg_data[6:0];
        REG_SIZE_Y: size_y   <= cfg_data[6:0];
        REG_SIZE_Z: size_z   <= cfg_data[10:0];
        REG_FACE:   face_w   <= cfg_data;
        REG_EDGE:   edge_w   <= cfg_data;
        REG_CORNER: corner_w <= cfg_data;
        default: ;
      endcase
    end
    plane <= {7'b0, sx} * {7'b0, sy};
    total <= {11'b0, plane} * {14'b0, sz};
  end

  // input and output counters
  always_ff @(posedge clk) begin
    if (rst || size_wr || cmd.restart ||
        (cmd.put && out_pos == last_pos)) begin
      in_pos   <= '0;
      out_pos  <= '0;
      wr_addr  <= '0;
      out_addr <= '0;
      ox       <= '0;
      oy       <= '0;
      oz       <= '0;
    end else begin
      if (cmd.take && !in_word.mode && (in_pos < total)) begin
        in_pos  <= in_pos + POS_W'(1);
        wr_addr <= (wr_addr == AW'(DEPTH - 1)) ? '0 : wr_addr + AW'(1);
      end
      if (cmd.put) begin
        out_pos  <= out_pos + POS_W'(1);
        out_addr <= (out_addr == AW'(DEPTH - 1)) ? '0 : out_addr + AW'(1);
        if (ox == sx - 7'd1) begin
          ox <= '0;
          if (oy == sy - 7'd1) begin
            oy <= '0;
            oz <= oz + 11'd1;
          end else begin
            oy <= oy + 7'd1;
          end
        end else begin
          ox <= ox + 7'd1;
        end
      end
    end
  end

  // walk the neighbourhood, weigh and sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      ndx  <= '0;
      ndy  <= '0;
      ndz  <= '0;
    end else begin
      s1_v <= cmd.nb_issue && inb && !is_center;
      s2_v <= s1_v;
      if (cmd.clr_acc) begin
        ndx <= '0;
        ndy <= '0;
        ndz <= '0;
      end else if (cmd.nb_issue) begin
        if (ndx == 2'd2) begin
          ndx <= '0;
          if (ndy == 2'd2) begin
            ndy <= '0;
            ndz <= ndz + 2'd1;
          end else begin
            ndy <= ndy + 2'd1;
          end
        end else begin
          ndx <= ndx + 2'd1;
        end
      end
    end
    s1_k <= kw;
    s2_w <= {16'b0, rdata[STORE_W-1:8]} * {16'b0, s1_k};
    s2_i <= rdata[7:0];
    if (cmd.clr_acc) begin
      num <= '0;
      den <= '0;
    end else if (s2_v) begin
      num <= num + NUM_W'({32'b0, s2_i} * {8'b0, s2_w});
      den <= den + DEN_W'(s2_w);
    end
  end

  // divide one bit a cycle, load the result
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= num;
      quo  <= '0;
      dbit <= 3'd7;
    end else if (cmd.div_step) begin
      if (dge) begin
        rem <= rem - dshift;
      end
      quo  <= quo_next;
      dbit <= dbit - 3'd1;
      if (dbit == 3'd0) begin
        res_val   <= (den == '0) ? 8'd0 : quo_next;
        res_alpha <= (den == '0) ? 8'd0 : OPAQUE;
      end
    end
    if (cmd.load_pass) begin
      res_val   <= rdata[7:0];
      res_alpha <= OPAQUE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.put) begin
      out_word.filled_value <= res_val;
      out_word.alpha        <= res_alpha;
      out_word.final_voxel  <= out_pos == last_pos;
    end
  end

  a_in_bound: assert property (@(posedge clk) disable iff (rst)
    in_pos <= total)
    else $error("input counter past the volume");
  a_out_behind: assert property (@(posedge clk) disable iff (rst)
    out_pos <= in_pos)
    else $error("output ahead of input");
  a_put_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_center |-> (sts.emit && !sts.over))
    else $error("output voxel read before its window is complete");

endmodule
